FILE: rtl/bhpq_pkg.sv
`timescale 1ns / 1ps

package bhpq_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = ADDR_W + 1;
   localparam int ENTRY_W  = 48;

   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_EXTRACT = 2'd1;
   localparam logic [1:0] MODE_CLEAR   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] node_index;
      logic [15:0] key_dist;
      logic [15:0] key_packed;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] best_index;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] node_index;
      logic [15:0] key_dist;
      logic [15:0] key_packed;
   } entry_type;

   // strict ordering: smaller distance, then larger packed value, then smaller index
   function automatic logic ahead_of(entry_type a, entry_type b);
      logic result;
      if (a.key_dist != b.key_dist) begin
         result = a.key_dist < b.key_dist;
      end else if (a.key_packed != b.key_packed) begin
         result = a.key_packed > b.key_packed;
      end else begin
         result = a.node_index < b.node_index;
      end
      return result;
   endfunction

endpackage

FILE: rtl/bhpq_ram.sv
`timescale 1ns / 1ps

module bhpq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

FILE: rtl/binary_heap_priority_queue_core.sv
`timescale 1ns / 1ps

// Priority queue of node entries kept as a binary heap in one block RAM.
// req channel: one operation per transfer (insert, extract best, clear).
// rsp channel: exactly one result per operation, in order: status, the node
// index removed by an extract (zero otherwise) and the entry count afterwards.
// Operations run one at a time; req_stall is high while one is in flight.
// Clear, an unused mode, extract on empty, insert on full and insert into an
// empty queue go straight to the done state. An insert climbs at most
// log2(CAPACITY) levels; an extract loads the root and the last entry, and the
// last entry then sinks at most log2(CAPACITY) - 1 levels (none if it was the
// only entry). Each heap level takes one RAM read (the parent on port a, or
// both children at once on the two read ports) and one write back of the moved
// entry. The next request can be taken as soon as rsp valid rises.
// The finished result sits in an output register; the next request is taken
// while it waits, and a stalled rsp only holds the block once the next result
// is ready. Synchronous reset empties the queue; the RAM itself is not cleared.
module binary_heap_priority_queue_core
   import bhpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP,
      S_EXT_LOAD,
      S_DOWN,
      S_WRITE_E,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]    i_ff, i_in;
   entry_type            e_ff, e_in;
   logic [1:0]           status_ff, status_in;
   logic [15:0]          best_ff, best_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   entry_type            wr_data;
   logic [ADDR_W-1:0]    rd_addr_a, rd_addr_b;
   entry_type            rd_data_a, rd_data_b;

   logic                 accept;
   logic [ADDR_W-1:0]    parent;
   entry_type            cand;
   logic                 take_l, take_r;
   logic [ADDR_W-1:0]    sel;
   logic [CHILD_W-1:0]   child_l;
   logic [CHILD_W-1:0]   next_l;
   logic                 r_valid;

   bhpq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(CAPACITY)
   ) u_heap_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_data_a(rd_data_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_b(rd_data_b)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      e_in         = e_ff;
      status_in    = status_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = i_ff;
      wr_data      = e_ff;
      rd_addr_a    = '0;
      rd_addr_b    = '0;

      parent  = ADDR_W'((i_ff - ADDR_W'(1)) >> 1);
      child_l = CHILD_W'({i_ff, 1'b1});
      r_valid = (child_l + CHILD_W'(1)) < CHILD_W'(count_ff);
      take_l  = ahead_of(rd_data_a, e_ff);
      cand    = take_l ? rd_data_a : e_ff;
      take_r  = r_valid && ahead_of(rd_data_b, cand);
      sel     = take_r ? ADDR_W'(child_l + CHILD_W'(1)) : ADDR_W'(child_l);
      next_l  = CHILD_W'({sel, 1'b1});

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = ST_OK;
               best_in   = '0;
               e_in      = '{node_index: req_data.node_index,
                             key_dist:   req_data.key_dist,
                             key_packed: req_data.key_packed};
               state_in  = S_DONE;
               case (req_data.mode)
                  MODE_INSERT: begin
                     if (count_ff >= COUNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        count_in = count_ff + COUNT_W'(1);
                        i_in     = ADDR_W'(count_ff);
                        if (count_ff == '0) begin
                           wr_en   = 1'b1;
                           wr_addr = '0;
                           wr_data = e_in;
                        end else begin
                           rd_addr_a = ADDR_W'((count_ff - COUNT_W'(1)) >> 1);
                           state_in  = S_UP;
                        end
                     end
                  end
                  MODE_EXTRACT: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        count_in  = count_ff - COUNT_W'(1);
                        rd_addr_a = '0;
                        rd_addr_b = ADDR_W'(count_ff - COUNT_W'(1));
                        state_in  = S_EXT_LOAD;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_UP: begin
            // parent entry is on read port a
            if (ahead_of(e_ff, rd_data_a)) begin
               wr_en     = 1'b1;
               wr_addr   = i_ff;
               wr_data   = rd_data_a;
               i_in      = parent;
               rd_addr_a = ADDR_W'((parent - ADDR_W'(1)) >> 1);
               if (parent == '0) begin
                  state_in = S_WRITE_E;
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = i_ff;
               wr_data  = e_ff;
               state_in = S_DONE;
            end
         end
         S_EXT_LOAD: begin
            best_in = rd_data_a.node_index;
            e_in    = rd_data_b;
            i_in    = '0;
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else if (count_ff == COUNT_W'(1)) begin
               state_in = S_WRITE_E;
            end else begin
               rd_addr_a = ADDR_W'(1);
               rd_addr_b = ADDR_W'(2);
               state_in  = S_DOWN;
            end
         end
         S_DOWN: begin
            // left child on port a is always inside the heap here
            if (!take_l && !take_r) begin
               wr_en    = 1'b1;
               wr_addr  = i_ff;
               wr_data  = e_ff;
               state_in = S_DONE;
            end else begin
               wr_en     = 1'b1;
               wr_addr   = i_ff;
               wr_data   = take_r ? rd_data_b : rd_data_a;
               i_in      = sel;
               rd_addr_a = ADDR_W'(next_l);
               rd_addr_b = ADDR_W'(next_l) + ADDR_W'(1);
               if (next_l >= CHILD_W'(count_ff)) begin
                  state_in = S_WRITE_E;
               end
            end
         end
         S_WRITE_E: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff;
            wr_data  = e_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status:      status_ff,
                                best_index:  best_ff,
                                entry_count: 7'(count_ff)};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      e_ff        <= e_in;
      status_ff   <= status_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("heap count above capacity");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (COUNT_W'($past(wr_addr)) < count_ff))
      else $error("heap write outside the valid entries");

   a_up_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP) |-> (i_ff != '0 && COUNT_W'(i_ff) < count_ff))
      else $error("sift up index out of range");

   a_done_leaves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !(rsp_valid_ff && rsp_stall)) |=>
         (state_ff == S_IDLE && rsp_valid_ff))
      else $error("finished result not moved to the output register");
`endif

endmodule
